/* design/hlg_pkg.sv */
`timescale 1ns / 1ps
// Shared types, constants and helper functions of the hint label generator.
package hlg_pkg;

  localparam int CHAR_SLOTS = 16;
  localparam int SLOT_W     = 4;
  localparam int DIGIT_W    = 4;
  localparam int CHAR_W     = 8;
  localparam int SIZE_W     = 5;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 64;
  localparam int LABEL_W    = 32;
  localparam int BIT_SEL_W  = 2;

  localparam logic [CFG_IDX_W-1:0] REG_ALPHABET_SIZE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_CHARS_LOW     = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_CHARS_HIGH    = 2'd2;

  localparam logic [SIZE_W-1:0] SIZE_RESET = 5'd16;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic                 load;
    logic                 search;
    logic                 dig_step;
    logic                 emit;
    logic                 last;
    logic                 no_hint;
    logic [SLOT_W-1:0]    slot;
    logic [BIT_SEL_W-1:0] bit_sel;
  } hlg_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic              found;
    logic              out_free;
    logic [SIZE_W-1:0] base;
  } hlg_status_t;

  // Picks the alphabet character for a digit out of the two packed words.
  function automatic logic [CHAR_W-1:0] char_of(input logic [CFG_DATA_W-1:0] lo,
                                               input logic [CFG_DATA_W-1:0] hi,
                                               input logic [DIGIT_W-1:0]    d);
    logic [CFG_DATA_W-1:0] w;
    w = d[DIGIT_W-1] ? hi : lo;
    return w[{d[DIGIT_W-2:0], 3'b000} +: CHAR_W];
  endfunction

endpackage

/* design/hlg_if.sv */
`timescale 1ns / 1ps
// Valid/ready channel interfaces for index requests, label characters and configuration.
interface hlg_req_if;
  logic                         valid;
  logic                         ready;
  logic [hlg_pkg::LABEL_W-1:0] label_index;

  modport source (output valid, output label_index, input ready);
  modport sink   (input valid, input label_index, output ready);
endinterface

interface hlg_label_if;
  logic                         valid;
  logic                         ready;
  logic [hlg_pkg::CHAR_W-1:0]  label_char;
  logic [hlg_pkg::DIGIT_W-1:0] digit_value;
  logic                         last_char;
  logic                         no_hint;

  modport source (output valid, output label_char, output digit_value, output last_char,
                  output no_hint, input ready);
  modport sink   (input valid, input label_char, input digit_value, input last_char,
                  input no_hint, output ready);
endinterface

interface hlg_cfg_if;
  logic                            valid;
  logic                            ready;
  logic [hlg_pkg::CFG_IDX_W-1:0]  index;
  logic [hlg_pkg::CFG_DATA_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

/* design/hlg_datapath.sv */
`timescale 1ns / 1ps
// Datapath: configuration registers, length search, power stack, digit unit and output word.
module hlg_datapath #(
  parameter int MAX_ALPHABET = 16,
  parameter int INDEX_BITS   = 32
) (
  input  logic                            clk,
  input  logic                            rst,
  input  hlg_pkg::hlg_cmd_t               cmd,
  output hlg_pkg::hlg_status_t            status,
  input  logic [hlg_pkg::LABEL_W-1:0]     label_index,
  input  logic                            cfg_valid,
  input  logic [hlg_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [hlg_pkg::CFG_DATA_W-1:0]  cfg_data,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [hlg_pkg::CHAR_W-1:0]      out_char,
  output logic [hlg_pkg::DIGIT_W-1:0]     out_digit,
  output logic                            out_last,
  output logic                            out_no_hint
);

  localparam int IW   = (INDEX_BITS < hlg_pkg::LABEL_W) ? INDEX_BITS : hlg_pkg::LABEL_W;
  localparam int SW   = hlg_pkg::SIZE_W;
  localparam int PW   = IW + SW;
  localparam int EW   = IW + 3;
  localparam int CAP  = (MAX_ALPHABET < hlg_pkg::CHAR_SLOTS) ? MAX_ALPHABET
                                                              : hlg_pkg::CHAR_SLOTS;
  localparam logic [SW-1:0] BASE_CAP = SW'(CAP);

  logic [SW-1:0]                    alphabet_size;
  logic [hlg_pkg::CFG_DATA_W-1:0]   chars_low;
  logic [hlg_pkg::CFG_DATA_W-1:0]   chars_high;
  logic [IW-1:0]                    rem;
  logic [IW-1:0]                    pow;
  logic [IW-1:0]                    pw [hlg_pkg::CHAR_SLOTS];
  logic [hlg_pkg::DIGIT_W-1:0]      digit;
  logic [SW-1:0]                    base;
  logic [PW-1:0]                    prod;
  logic                             found;
  logic [EW-1:0]                    trial;
  logic                             fits;

  always_comb begin
    base  = (alphabet_size > BASE_CAP) ? BASE_CAP : alphabet_size;
    prod  = PW'(pow) * PW'(base);
    found = PW'(rem) < prod;
    trial = EW'(pw[cmd.slot]) << cmd.bit_sel;
    fits  = EW'(rem) >= trial;
  end

  assign status.found    = found;
  assign status.out_free = !out_valid || out_ready;
  assign status.base     = base;

  always_ff @(posedge clk) begin
    if (rst) begin
      alphabet_size <= hlg_pkg::SIZE_RESET;
      chars_low     <= '0;
      chars_high    <= '0;
    end else if (cfg_valid) begin
      case (cfg_index)
        hlg_pkg::REG_ALPHABET_SIZE: alphabet_size <= cfg_data[SW-1:0];
        hlg_pkg::REG_CHARS_LOW:     chars_low     <= cfg_data;
        hlg_pkg::REG_CHARS_HIGH:    chars_high    <= cfg_data;
        default: ;
      endcase
    end
  end

  // Length search, power stack and restoring digit steps.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      rem <= label_index[IW-1:0];
      pow <= IW'(1);
    end else if (cmd.search) begin
      pw[cmd.slot] <= pow;
      if (!found) begin
        rem <= rem - prod[IW-1:0];
        pow <= prod[IW-1:0];
      end
    end else if (cmd.dig_step) begin
      digit[cmd.bit_sel] <= fits;
      if (fits) begin
        rem <= rem - trial[IW-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      if (cmd.no_hint) begin
        out_char    <= '0;
        out_digit   <= '0;
        out_last    <= 1'b0;
        out_no_hint <= 1'b1;
      end else begin
        out_char    <= hlg_pkg::char_of(chars_low, chars_high, digit);
        out_digit   <= digit;
        out_last    <= cmd.last;
        out_no_hint <= 1'b0;
      end
    end
  end

endmodule

/* design/hlg_ctrl.sv */
`timescale 1ns / 1ps
// Controller: sequences request intake, length search, digit steps and word output.
module hlg_ctrl (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   req_valid,
  output logic                   req_ready,
  output hlg_pkg::hlg_cmd_t      cmd,
  input  hlg_pkg::hlg_status_t   status
);

  localparam int CW = hlg_pkg::SLOT_W + 1;

  typedef enum logic [1:0] {
    IDLE,
    SEARCH,
    STEP,
    EMIT
  } state_t;

  state_t                           state;
  logic [CW-1:0]                    len;
  logic [hlg_pkg::SLOT_W-1:0]       slot;
  logic [hlg_pkg::BIT_SEL_W-1:0]    bit_sel;
  logic                             no_hint;
  logic [CW-1:0]                    len_m1;
  logic                             over;

  assign req_ready = (state == IDLE);
  assign len_m1    = len - CW'(1);
  assign over      = len > CW'(status.base);

  always_comb begin
    cmd          = '0;
    cmd.load     = (state == IDLE) && req_valid;
    cmd.search   = (state == SEARCH) && !over;
    cmd.dig_step = (state == STEP);
    cmd.emit     = (state == EMIT) && status.out_free;
    cmd.last     = (slot == '0);
    cmd.no_hint  = no_hint;
    cmd.bit_sel  = bit_sel;
    cmd.slot     = (state == SEARCH) ? len_m1[hlg_pkg::SLOT_W-1:0] : slot;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= IDLE;
      len     <= '0;
      slot    <= '0;
      bit_sel <= '0;
      no_hint <= 1'b0;
    end else begin
      case (state)
        IDLE: begin
          if (req_valid) begin
            len     <= CW'(1);
            no_hint <= 1'b0;
            state   <= SEARCH;
          end
        end
        SEARCH: begin
          if (over) begin
            no_hint <= 1'b1;
            state   <= EMIT;
          end else if (status.found) begin
            slot    <= len_m1[hlg_pkg::SLOT_W-1:0];
            bit_sel <= '1;
            state   <= STEP;
          end else begin
            len <= len + CW'(1);
          end
        end
        STEP: begin
          if (bit_sel == '0) begin
            state <= EMIT;
          end else begin
            bit_sel <= bit_sel - hlg_pkg::BIT_SEL_W'(1);
          end
        end
        EMIT: begin
          if (status.out_free) begin
            if (no_hint || slot == '0) begin
              state <= IDLE;
            end else begin
              slot    <= slot - hlg_pkg::SLOT_W'(1);
              bit_sel <= '1;
              state   <= STEP;
            end
          end
        end
        default: state <= IDLE;
      endcase
    end
  end

  a_emit_only_when_free: assert property (@(posedge clk) disable iff (rst)
    cmd.emit |-> status.out_free) else $error("word emitted while output register busy");

  a_accept_starts_search: assert property (@(posedge clk) disable iff (rst)
    (req_valid && req_ready) |=> (state == SEARCH && len == CW'(1)))
    else $error("accepted request did not start the length search");

  a_search_in_range: assert property (@(posedge clk) disable iff (rst)
    cmd.search |-> (len != '0 && len <= CW'(status.base)))
    else $error("search step beyond alphabet size");

  a_no_hint_single: assert property (@(posedge clk) disable iff (rst)
    (cmd.emit && cmd.no_hint) |=> (state == IDLE))
    else $error("no-hint result not followed by return to idle");

endmodule

/* design/hint_label_generator.sv */
`timescale 1ns / 1ps
// Top level of the hint label generator: controller, datapath and channel wiring.
// The block turns each request word (an index) into a label of L characters over a configured
// alphabet of n characters and emits one output word per character, most significant first,
// with last_char set on the final one. Labels of length 1 come first, then length 2, up to
// length n; an index past all of them yields a single word with no_hint set and all other
// fields zero. One request is handled at a time: after acceptance the length search tries each
// candidate length in turn (one multiply by n and one compare each), then every character
// takes four restoring compare-subtract steps against a stored power of n and then a load of
// the output register, which waits while the output side stalls. The next request is taken as
// soon as the last word sits in the output register, even if it has not yet been taken.
// Configuration writes are always ready and are registered; write them only while the block is
// idle. The alphabet size is clamped to MAX_ALPHABET and to 16, and the index is masked to
// INDEX_BITS bits.
module hint_label_generator #(
  parameter int MAX_ALPHABET = 16,
  parameter int INDEX_BITS   = 32
) (
  input  logic          clk,
  input  logic          rst,
  hlg_req_if.sink       request,
  hlg_label_if.source   label,
  hlg_cfg_if.sink       cfg
);

  hlg_pkg::hlg_cmd_t    cmd;
  hlg_pkg::hlg_status_t status;
  logic                 req_ready;

  // Configuration registers never stall.
  assign cfg.ready     = 1'b1;
  assign request.ready = req_ready;

  hlg_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (request.valid),
    .req_ready (req_ready),
    .cmd       (cmd),
    .status    (status)
  );

  hlg_datapath #(
    .MAX_ALPHABET (MAX_ALPHABET),
    .INDEX_BITS   (INDEX_BITS)
  ) u_datapath (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .status      (status),
    .label_index (request.label_index),
    .cfg_valid   (cfg.valid),
    .cfg_index   (cfg.index),
    .cfg_data    (cfg.data),
    .out_valid   (label.valid),
    .out_ready   (label.ready),
    .out_char    (label.label_char),
    .out_digit   (label.digit_value),
    .out_last    (label.last_char),
    .out_no_hint (label.no_hint)
  );

endmodule
